@@ rtl/tmps_pkg.sv @@
// Package with the shared types and constants of the triangle minimum path sum unit.
package tmps_pkg;

  // Default buffer depth, which is also the largest triangle the chain holds.
  localparam int MAX_ROWS_DEF = 256;

  // Field widths.
  localparam int ROW_W  = 9;
  localparam int ELEM_W = 16;
  localparam int SUM_W  = 32;

  // Saturation limits of a path sum.
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Input word: one triangle element.
  typedef struct packed {
    logic signed [ELEM_W-1:0] element_value;
    logic                     first_item;
  } item_t;

  // Output word: one finished triangle.
  typedef struct packed {
    logic signed [SUM_W-1:0] min_sum;
    logic                    saturated;
  } result_t;

  // What a word does when it reaches the cell of its column.
  typedef enum logic [1:0] {
    OP_STORE        = 2'd0,  // bottom row: write the element
    OP_COMBINE      = 2'd1,  // higher row: write element plus smaller neighbor
    OP_APEX_DIRECT  = 2'd2,  // one-row triangle: the element is the answer
    OP_APEX_COMBINE = 2'd3   // apex: element plus smaller neighbor is the answer
  } op_t;

  // A word as it travels down the chain of cells.
  typedef struct packed {
    logic                     valid;
    op_t                      op;
    logic                     clr;   // first element of a new triangle
    logic                     sat;   // this word's sum was clamped
    logic signed [ELEM_W-1:0] e;
    logic signed [SUM_W-1:0]  acc;   // right neighbor sum, then the apex total
  } flow_t;

endpackage

@@ rtl/tmps_front.sv @@
// Row and column tracking that turns each accepted element into a chain word.
module tmps_front
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  logic                            item_valid,
  input  item_t                           item,
  input  logic [ROW_W-1:0]                row_total,
  output flow_t                           flow,
  output logic [$clog2(MAX_ROWS)-1:0]     col
);

  localparam int COL_W = $clog2(MAX_ROWS);

  logic [ROW_W-1:0] row_index;
  logic [ROW_W-1:0] row_index_next;
  logic [COL_W-1:0] column_index;
  logic [COL_W-1:0] column_index_next;

  logic [ROW_W-1:0] rows;
  logic [ROW_W-1:0] r0;
  logic [COL_W-1:0] c0;
  logic [ROW_W-1:0] len;
  logic             apex;
  logic             row_end;

  // Effective row count, then decode of the incoming element's position.
  always_comb begin
    if (row_total == '0) begin
      rows = ROW_W'(1);
    end else if (32'(row_total) > 32'(MAX_ROWS)) begin
      rows = ROW_W'(MAX_ROWS);
    end else begin
      rows = row_total;
    end

    r0 = item.first_item ? '0 : row_index;
    c0 = item.first_item ? '0 : column_index;

    apex    = (rows == ROW_W'(1)) || ((r0 != '0) && (r0 >= rows - ROW_W'(1)));
    len     = rows - r0;
    row_end = (32'(c0) + 32'd1) >= 32'(len);

    flow.valid = item_valid;
    flow.clr   = item.first_item;
    flow.sat   = 1'b0;
    flow.e     = item.element_value;
    flow.acc   = {{(SUM_W-ELEM_W){item.element_value[ELEM_W-1]}}, item.element_value};
    col        = c0;

    if (apex) begin
      col               = '0;
      flow.op           = (r0 == '0) ? OP_APEX_DIRECT : OP_APEX_COMBINE;
      row_index_next    = '0;
      column_index_next = '0;
    end else begin
      flow.op = (r0 == '0) ? OP_STORE : OP_COMBINE;
      if (row_end) begin
        row_index_next    = r0 + ROW_W'(1);
        column_index_next = '0;
      end else begin
        row_index_next    = r0;
        column_index_next = c0 + COL_W'(1);
      end
    end
  end

  // Counters move only when an element is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_index    <= '0;
      column_index <= '0;
    end else if (take) begin
      row_index    <= row_index_next;
      column_index <= column_index_next;
    end
  end

endmodule

@@ rtl/tmps_cell.sv @@
// One cell of the chain: one row buffer entry and one pipeline stage.
module tmps_cell
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int IDX      = 0
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  flow_t                           in_flow,
  input  logic [$clog2(MAX_ROWS)-1:0]     in_col,
  output flow_t                           out_flow,
  output logic [$clog2(MAX_ROWS)-1:0]     out_col
);

  localparam int COL_W = $clog2(MAX_ROWS);

  flow_t                   flow;
  logic [COL_W-1:0]        col;
  logic signed [SUM_W-1:0] path_sum;

  logic                    hit_a;
  logic                    hit_b;
  logic                    wr_en;
  logic signed [SUM_W-1:0] wr_data;
  logic signed [SUM_W-1:0] b_eff;
  logic signed [SUM_W-1:0] pick;
  logic signed [SUM_W:0]   wide;
  logic signed [SUM_W-1:0] sum;
  logic                    ovf;

  // Column match, smaller neighbor, saturating add and the word handed on.
  always_comb begin
    hit_a = flow.valid && (col == COL_W'(IDX));
    hit_b = flow.valid && (({1'b0, col} + (COL_W+1)'(1)) == (COL_W+1)'(IDX));

    // The rightmost entry is its own right neighbor.
    b_eff = (col == COL_W'(MAX_ROWS - 1)) ? path_sum : flow.acc;
    pick  = (path_sum < b_eff) ? path_sum : b_eff;
    wide  = {{(SUM_W+1-ELEM_W){flow.e[ELEM_W-1]}}, flow.e} + {pick[SUM_W-1], pick};
    ovf   = (wide[SUM_W] != wide[SUM_W-1]);
    if (ovf) begin
      sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sum = wide[SUM_W-1:0];
    end

    out_flow = flow;
    out_col  = col;
    wr_en    = 1'b0;
    wr_data  = sum;

    if (hit_b && ((flow.op == OP_COMBINE) || (flow.op == OP_APEX_COMBINE))) begin
      out_flow.acc = path_sum;
    end

    if (hit_a) begin
      unique case (flow.op)
        OP_STORE: begin
          wr_en   = 1'b1;
          wr_data = {{(SUM_W-ELEM_W){flow.e[ELEM_W-1]}}, flow.e};
        end
        OP_COMBINE: begin
          wr_en        = 1'b1;
          out_flow.sat = ovf;
        end
        OP_APEX_COMBINE: begin
          out_flow.acc = sum;
          out_flow.sat = ovf;
        end
        OP_APEX_DIRECT: begin
          out_flow.acc = flow.acc;
        end
      endcase
    end
  end

  // Stage register; the whole chain moves together.
  always_ff @(posedge clk) begin
    if (rst) begin
      flow.valid <= 1'b0;
    end else if (advance) begin
      flow <= in_flow;
      col  <= in_col;
    end
  end

  // Row buffer entry, written in place by the word of this column.
  always_ff @(posedge clk) begin
    if (advance && wr_en) begin
      path_sum <= wr_data;
    end
  end

endmodule

@@ rtl/tmps_exit.sv @@
// Saturation tracking and output register at the end of the chain.
module tmps_exit
  import tmps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  flow_t   flow,
  output logic    hold,
  input  logic    result_stall,
  output logic    result_valid,
  output result_t result
);

  logic sat_seen;
  logic exit_apex;
  logic sat_cur;

  // An apex word may leave only when the output register can take it.
  always_comb begin
    exit_apex = flow.valid &&
                ((flow.op == OP_APEX_DIRECT) || (flow.op == OP_APEX_COMBINE));
    hold      = result_valid && result_stall && exit_apex;
    sat_cur   = (flow.clr ? 1'b0 : sat_seen) | flow.sat;
  end

  // Sticky flag, cleared at a new triangle and after each apex.
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_seen <= 1'b0;
    end else if (advance && flow.valid) begin
      sat_seen <= exit_apex ? 1'b0 : sat_cur;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && exit_apex) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && exit_apex) begin
      result.min_sum   <= flow.acc;
      result.saturated <= sat_cur;
    end
  end

endmodule

@@ rtl/triangle_min_path_sum_unit.sv @@
// Top level of the triangle minimum path sum unit: front end, chain of cells, output.
//
//   channel  direction  handshake                payload
//   item     in         item_valid / item_stall  item_t   (element_value, first_item)
//   result   out        result_valid / result_stall  result_t (min_sum, saturated)
//   cfg      in         cfg_valid / cfg_ready    cfg_row_total (9 bits)
//
// One element is taken every cycle while item_stall is low. Each word walks the chain
// of MAX_ROWS cells one cell per cycle while advance is high, toward the output register.
// Reset clears the counters, the stage valid bits, the flag and the output valid bit;
// the buffer entries hold nothing meaningful until written by a bottom row.
// A result stall holds the chain only while an apex word waits behind a full output
// register; cfg_ready is always high.
module triangle_min_path_sum_unit
  import tmps_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_stall,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [ROW_W-1:0] cfg_row_total
);

  localparam int COL_W = $clog2(MAX_ROWS);

  logic [ROW_W-1:0] row_total;
  logic             advance;
  logic             hold;
  logic             take;

  flow_t            link_flow [MAX_ROWS+1];
  logic [COL_W-1:0] link_col  [MAX_ROWS+1];

  // Chain control.
  assign advance    = !hold;
  assign item_stall = hold;
  assign take       = item_valid && advance;
  assign cfg_ready  = 1'b1;

  // Row count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_total <= ROW_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      row_total <= cfg_row_total;
    end
  end

  tmps_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item_valid (item_valid),
    .item       (item),
    .row_total  (row_total),
    .flow       (link_flow[MAX_ROWS]),
    .col        (link_col[MAX_ROWS])
  );

  // Words enter at the highest cell and move toward cell zero.
  for (genvar k = 0; k < MAX_ROWS; k++) begin : g_cell
    tmps_cell #(
      .MAX_ROWS (MAX_ROWS),
      .IDX      (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_flow  (link_flow[k+1]),
      .in_col   (link_col[k+1]),
      .out_flow (link_flow[k]),
      .out_col  (link_col[k])
    );
  end

  tmps_exit u_exit (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .flow         (link_flow[0]),
    .hold         (hold),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the triangle minimum path sum unit.
module testbench;
  import tmps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = MAX_ROWS_DEF;
  localparam int QUIET_LIMIT  = 4000;
  localparam longint SUM_HI   = 64'sd2147483647;
  localparam longint SUM_LO   = -64'sd2147483648;

  // One line of the directed table: a register write or an element word.
  typedef struct {
    bit               is_cfg;
    logic [ROW_W-1:0] cfg;
    item_t            w;
    bit               typed;
    result_t          want;
  } step_t;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  item_t            item;
  logic             result_valid;
  logic             result_stall;
  result_t          result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [ROW_W-1:0] cfg_row_total;

  // Side band that travels with each element word: a hand-written expectation.
  logic    note_typed;
  result_t note_want;

  // Predictor state.
  longint           row_sums [DEPTH];
  logic [ROW_W-1:0] rows_done;
  int               col_pos;
  bit               clamp_seen;
  logic [ROW_W-1:0] row_setting;

  result_t sum_queue [$];
  int      fail_count;
  int      quiet_cycles;
  int      burst_left;
  int      phase_items;
  step_t   dir_steps [$];

  // Set when a triangle was left unfinished; the next one must start with a mark.
  bit      open_tri;

  triangle_min_path_sum_unit dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_row_total (cfg_row_total)
  );

  // Row count in effect: zero acts as one, anything past the buffer as its depth.
  function automatic int active_rows(logic [ROW_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > DEPTH) return DEPTH;
    return setting;
  endfunction

  function automatic int buf_slot(int j);
    return (j >= DEPTH) ? DEPTH - 1 : j;
  endfunction

  // Element plus the smaller of the sums at j and j+1, clamped to 32 bits.
  function automatic longint add_smaller(longint e, int j);
    longint a;
    longint b;
    longint s;
    a = row_sums[buf_slot(j)];
    b = row_sums[buf_slot(j + 1)];
    s = e + ((a < b) ? a : b);
    if (s > SUM_HI) begin
      clamp_seen = 1'b1;
      s = SUM_HI;
    end else if (s < SUM_LO) begin
      clamp_seen = 1'b1;
      s = SUM_LO;
    end
    return s;
  endfunction

  // Folds one element into the row buffer; returns 1 with the total at the apex.
  function automatic bit fold_element(item_t w, output result_t r);
    longint e;
    longint s;
    int     rows;
    e = longint'($signed(w.element_value));
    rows = active_rows(row_setting);
    r = '0;
    if (w.first_item) begin
      rows_done = '0;
      col_pos = 0;
      clamp_seen = 1'b0;
    end
    if (rows == 1 || (rows_done > 0 && rows_done >= rows - 1)) begin
      s = (rows_done == 0) ? e : add_smaller(e, 0);
      r.min_sum = s[SUM_W-1:0];
      r.saturated = clamp_seen;
      rows_done = '0;
      col_pos = 0;
      clamp_seen = 1'b0;
      return 1'b1;
    end
    if (rows_done == 0)
      row_sums[buf_slot(col_pos)] = e;
    else
      row_sums[buf_slot(col_pos)] = add_smaller(e, col_pos);
    if (col_pos + 1 >= rows - rows_done) begin
      col_pos = 0;
      rows_done = rows_done + 1'b1;
    end else begin
      col_pos++;
    end
    return 1'b0;
  endfunction

  function automatic step_t mk(bit is_cfg, int cfg, int v, bit first, bit typed, int want);
    step_t s;
    s.is_cfg = is_cfg;
    s.cfg = cfg[ROW_W-1:0];
    s.w.element_value = v[ELEM_W-1:0];
    s.w.first_item = first;
    s.typed = typed;
    s.want.min_sum = want;
    s.want.saturated = 1'b0;
    return s;
  endfunction

  // Element values lean on the two extremes and on small numbers.
  function automatic logic [ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 40) - 20);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver stalls in short bursts between runs of random length.
  initial begin
    result_stall <= 1'b0;
    forever begin
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30))
        @(posedge clk);
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      result_stall <= 1'b0;
    end
  end

  // Offers one word, opening a new burst after a random gap when the last one ran out.
  task automatic send_word(item_t w, bit typed, result_t want);
    if (burst_left == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
    end
    item_valid <= 1'b1;
    item <= w;
    note_typed <= typed;
    note_want <= want;
    do @(posedge clk); while (item_stall);
    burst_left--;
    phase_items++;
  endtask

  // Lets the block drain, then writes the row count.
  task automatic write_rows(logic [ROW_W-1:0] v);
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_row_total <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One whole triangle, optionally preceded by an abandoned start that gets restarted.
  task automatic send_triangle(int rows, bit broken);
    int    total;
    int    cut;
    item_t w;
    total = rows * (rows + 1) / 2;
    if (broken && total > 1) begin
      cut = $urandom_range(1, total - 1);
      for (int i = 0; i < cut; i++) begin
        w.element_value = pick_value();
        w.first_item = (i == 0) ? (open_tri || 1'($urandom_range(0, 1))) :
                                  ($urandom_range(0, 9) == 0);
        send_word(w, 1'b0, '0);
      end
    end
    for (int i = 0; i < total; i++) begin
      w.element_value = pick_value();
      w.first_item = (i == 0) && (broken || open_tri || $urandom_range(0, 3) != 0);
      send_word(w, 1'b0, '0);
    end
    open_tri = 1'b0;
  endtask

  // Stimulus: directed table, then random phases over several row counts.
  initial begin
    int phase_rows [14] = '{1, 2, 4, 3, 7, 0, 12, 5, 256, 20, 9, 511, 6, 2};
    int rows;
    item_t part;

    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    note_typed <= 1'b0;
    note_want <= '0;
    cfg_valid <= 1'b0;
    cfg_row_total <= '0;
    burst_left = 0;
    open_tri = 1'b0;

    // One row after reset: every element is its own total.
    dir_steps.push_back(mk(0, 0, -32768, 1, 1, -32768));
    dir_steps.push_back(mk(0, 0, 32767, 0, 1, 32767));
    dir_steps.push_back(mk(0, 0, 0, 1, 1, 0));
    dir_steps.push_back(mk(0, 0, -1, 0, 1, -1));
    // A zero row count behaves as one row.
    dir_steps.push_back(mk(1, 0, 0, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 12345, 0, 1, 12345));
    // Two rows: the apex adds the smaller of the two bottom entries.
    dir_steps.push_back(mk(1, 2, 0, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 5, 1, 0, 0));
    dir_steps.push_back(mk(0, 0, -3, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 10, 0, 1, 7));
    dir_steps.push_back(mk(0, 0, 32767, 1, 0, 0));
    dir_steps.push_back(mk(0, 0, 32767, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 32767, 0, 1, 65534));
    // Three rows: an abandoned start, then a restart with all minimum values.
    dir_steps.push_back(mk(1, 3, 0, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 1, 1, 0, 0));
    dir_steps.push_back(mk(0, 0, 2, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, -32768, 1, 0, 0));
    for (int i = 0; i < 4; i++) dir_steps.push_back(mk(0, 0, -32768, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, -32768, 0, 1, -98304));
    // Next triangle starts without the first-item mark.
    dir_steps.push_back(mk(0, 0, 7, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, -9, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 4, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 1, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 2, 0, 0, 0));
    dir_steps.push_back(mk(0, 0, 3, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg)
        write_rows(dir_steps[i].cfg);
      else
        send_word(dir_steps[i].w, dir_steps[i].typed, dir_steps[i].want);
    end

    // Random phases; a full-size triangle only gets part of its bottom row.
    for (int p = 0; p < 15; p++) begin
      rows = (p < 14) ? phase_rows[p] : $urandom_range(1, 24);
      write_rows(rows[ROW_W-1:0]);
      phase_items = 0;
      if (active_rows(rows[ROW_W-1:0]) == DEPTH) begin
        for (int i = 0; i < 40; i++) begin
          part.element_value = pick_value();
          part.first_item = (i == 0);
          send_word(part, 1'b0, '0);
        end
        open_tri = 1'b1;
      end else begin
        while (phase_items < 36)
          send_triangle(active_rows(rows[ROW_W-1:0]), $urandom_range(0, 4) == 0);
      end
    end

    // Drain, then allow the chain latency before the verdict.
    item_valid <= 1'b0;
    @(posedge clk);
    while (sum_queue.size() != 0) @(posedge clk);
    repeat (DEPTH + 20) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Prediction on accepted words, checking of accepted results, and the watchdog.
  always @(posedge clk) begin
    result_t guess;
    result_t want;
    bit      busy;
    if (rst) begin
      rows_done = '0;
      col_pos = 0;
      clamp_seen = 1'b0;
      row_setting = 9'd1;
      quiet_cycles = 0;
      fail_count = fail_count;
    end else begin
      busy = 1'b0;
      if (cfg_valid && cfg_ready) begin
        row_setting = cfg_row_total;
        busy = 1'b1;
      end
      if (item_valid && !item_stall) begin
        busy = 1'b1;
        if (fold_element(item, guess))
          sum_queue.push_back(note_typed ? note_want : guess);
      end
      if (result_valid && !result_stall) begin
        busy = 1'b1;
        if (sum_queue.size() == 0) begin
          $error("result word with no total pending: min_sum %0d", result.min_sum);
          fail_count++;
        end else begin
          want = sum_queue.pop_front();
          if (result.min_sum !== want.min_sum) begin
            $error("min_sum: expected %0d, got %0d", want.min_sum, result.min_sum);
            fail_count++;
          end
          if (result.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, result.saturated);
            fail_count++;
          end
        end
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial fail_count = 0;

endmodule
